### src/pte_pkg.sv
package pte_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned VERSION_W       = 16;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned POS_W           = 3;
  localparam int unsigned BIF_W           = 3;
  localparam int unsigned STORE_DEPTH     = 6;
  localparam int unsigned IDX_MAX_BYTES   = 5;
  localparam int unsigned OUT_DATA_W      = 7 * WORD_W;

  localparam logic [VERSION_W-1:0] DWORD_PKG_VERSION = 16'd60;

  localparam logic [BIF_W-1:0] IDX_LAST_BYTE = BIF_W'(IDX_MAX_BYTES - 1);
  localparam logic [BIF_W-1:0] DWORD_LAST_BYTE = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PACKAGE_VERSION = 1'b0,
    CFG_TABLE_KIND      = 1'b1
  } cfg_idx_e;

  // field positions within an entry
  localparam logic [POS_W-1:0] FLD_REF_A   = 3'd0;
  localparam logic [POS_W-1:0] FLD_REF_B   = 3'd1;
  localparam logic [POS_W-1:0] FLD_PACKAGE = 3'd2;
  localparam logic [POS_W-1:0] FLD_OBJECT  = 3'd3;
  localparam logic [POS_W-1:0] FLD_FLAGS   = 3'd4;
  localparam logic [POS_W-1:0] FLD_SIZE    = 3'd5;
  localparam logic [POS_W-1:0] FLD_OFFSET  = 3'd6;

  typedef struct packed {
    logic                     done;
    logic                     neg;
    logic [WORD_W-1:0]        acc;
    logic [WORD_W-1:0]        value;
  } dec_t;

  typedef struct packed {
    logic                     entry_kind;
    logic signed [WORD_W-1:0] serial_offset;
    logic signed [WORD_W-1:0] serial_size;
    logic        [WORD_W-1:0] object_flags;
    logic signed [WORD_W-1:0] object_name;
    logic signed [WORD_W-1:0] package_ref;
    logic signed [WORD_W-1:0] ref_b;
    logic signed [WORD_W-1:0] ref_a;
  } record_t;

endpackage

### src/pte_field_decode.sv
module pte_field_decode (
  input  logic [pte_pkg::BYTE_W-1:0] byte_i,
  input  logic [pte_pkg::BIF_W-1:0]  byte_in_field_i,
  input  logic [pte_pkg::WORD_W-1:0] acc_i,
  input  logic                       neg_i,
  input  logic                       is_dword_i,
  output pte_pkg::dec_t              dec_o
);
  import pte_pkg::*;

  logic [WORD_W-1:0] byte_ext;
  logic [WORD_W-1:0] low7_ext;
  logic [WORD_W-1:0] idx_part;
  logic [BIF_W-1:0]  n_minus1;

  assign byte_ext = {{(WORD_W-BYTE_W){1'b0}}, byte_i};
  assign low7_ext = {{(WORD_W-7){1'b0}}, byte_i[6:0]};
  assign n_minus1 = byte_in_field_i - 3'd1;

  // later index bytes land at bits 6, 13, 20, 27
  always_comb begin
    case (n_minus1[1:0])
      2'd0:    idx_part = low7_ext << 6;
      2'd1:    idx_part = low7_ext << 13;
      2'd2:    idx_part = low7_ext << 20;
      2'd3:    idx_part = low7_ext << 27;
      default: idx_part = '0;
    endcase
  end

  always_comb begin
    dec_o = '0;
    if (is_dword_i) begin
      dec_o.acc  = acc_i | (byte_ext << {byte_in_field_i[1:0], 3'b000});
      dec_o.neg  = 1'b0;
      dec_o.done = (byte_in_field_i >= DWORD_LAST_BYTE);
    end else if (byte_in_field_i == '0) begin
      dec_o.acc  = {{(WORD_W-6){1'b0}}, byte_i[5:0]};
      dec_o.neg  = byte_i[7];
      dec_o.done = !byte_i[6];
    end else begin
      dec_o.acc  = acc_i | idx_part;
      dec_o.neg  = neg_i;
      dec_o.done = !byte_i[7] || (byte_in_field_i >= IDX_LAST_BYTE);
    end
    dec_o.value = dec_o.neg ? (WORD_W'(0) - dec_o.acc) : dec_o.acc;
  end

endmodule

### src/pte_record_reg.sv
module pte_record_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  pte_pkg::record_t     record_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output pte_pkg::record_t     record_o
);
  import pte_pkg::*;

  logic    valid_q, valid_d;
  record_t record_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      record_q <= record_i;
    end
  end

  assign valid_o  = valid_q;
  assign record_o = record_q;

endmodule

### src/package_table_entry_parser.sv
// path: a byte is taken into an input register; when it completes an entry, its
// record is loaded into a result register and shown from there
// throughput: one byte per cycle; a stalled record holds the input stage
// reset: asynchronous, active low; clears config, field position, byte count,
// accumulator and handshake state
module package_table_entry_parser (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pte_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pte_pkg::VERSION_W-1:0]        cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // data_byte
  input  logic [pte_pkg::BYTE_W-1:0]           s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // ref_a, ref_b, package_ref, object_name, object_flags, serial_size, serial_offset
  output logic [pte_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // entry_kind
  output logic                                 m_axis_tuser
);
  import pte_pkg::*;

  logic [VERSION_W-1:0] version_q;
  logic                 kind_q;

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BIF_W-1:0]  bif_q, bif_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic              neg_q, neg_d;
  logic [WORD_W-1:0] store_q [STORE_DEPTH];
  logic [WORD_W-1:0] view   [STORE_DEPTH];

  logic    out_free;
  logic    advance;
  logic    is_dword;
  logic    entry_end;
  logic    load;
  dec_t    dec;
  record_t rec;
  record_t rec_out;

  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  assign is_dword = ((pos_q == FLD_PACKAGE) && (version_q >= DWORD_PKG_VERSION)) ||
                    ((pos_q == FLD_FLAGS) && kind_q);

  pte_field_decode u_decode (
    .byte_i          (in_byte_q),
    .byte_in_field_i (bif_q),
    .acc_i           (acc_q),
    .neg_i           (neg_q),
    .is_dword_i      (is_dword),
    .dec_o           (dec)
  );

  always_comb begin
    if (!kind_q) begin
      entry_end = (pos_q >= FLD_OBJECT);
    end else if (pos_q == FLD_SIZE) begin
      // offset follows only a positive size
      entry_end = !(!dec.value[WORD_W-1] && (dec.value != '0));
    end else begin
      entry_end = (pos_q >= FLD_OFFSET);
    end
  end

  // stored fields with the one finishing now folded in
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      view[i] = (pos_q == POS_W'(i)) ? dec.value : store_q[i];
    end
  end

  always_comb begin
    rec.entry_kind    = kind_q;
    rec.ref_a         = view[FLD_REF_A];
    rec.ref_b         = view[FLD_REF_B];
    rec.package_ref   = view[FLD_PACKAGE];
    rec.object_name   = view[FLD_OBJECT];
    rec.object_flags  = kind_q ? view[FLD_FLAGS] : '0;
    rec.serial_size   = kind_q ? view[FLD_SIZE] : '0;
    rec.serial_offset = (kind_q && (pos_q == FLD_OFFSET)) ? dec.value : '0;
  end

  assign load = advance && dec.done && entry_end;

  always_comb begin
    pos_d = pos_q;
    bif_d = bif_q;
    acc_d = acc_q;
    neg_d = neg_q;
    if (cfg_we_i) begin
      pos_d = FLD_REF_A;
      bif_d = '0;
      acc_d = '0;
      neg_d = 1'b0;
    end else if (advance) begin
      if (!dec.done) begin
        bif_d = bif_q + 3'd1;
        acc_d = dec.acc;
        neg_d = dec.neg;
      end else begin
        bif_d = '0;
        acc_d = '0;
        neg_d = 1'b0;
        pos_d = entry_end ? FLD_REF_A : (pos_q + 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q  <= '0;
      kind_q     <= 1'b0;
      in_valid_q <= 1'b0;
      pos_q      <= FLD_REF_A;
      bif_q      <= '0;
      acc_q      <= '0;
      neg_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PACKAGE_VERSION: version_q <= cfg_wdata_i;
          CFG_TABLE_KIND:      kind_q    <= cfg_wdata_i[0];
          default:             ;
        endcase
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      pos_q <= pos_d;
      bif_q <= bif_d;
      acc_q <= acc_d;
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && dec.done && (pos_q < POS_W'(STORE_DEPTH))) begin
      store_q[pos_q] <= dec.value;
    end
  end

  pte_record_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .record_i (rec),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .record_o (rec_out)
  );

  assign m_axis_tuser = rec_out.entry_kind;
  assign m_axis_tdata = {rec_out.serial_offset, rec_out.serial_size, rec_out.object_flags,
                         rec_out.object_name, rec_out.package_ref, rec_out.ref_b,
                         rec_out.ref_a};

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= FLD_OFFSET)
    else $error("field position past last field");

  a_import_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !kind_q |-> (pos_q <= FLD_OBJECT))
    else $error("import entry past object name");

  a_bif_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bif_q <= IDX_LAST_BYTE)
    else $error("field longer than an index allows");

  a_rec_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(advance))
    else $error("record appeared without a byte being processed");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pte_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned ITEM_TARGET = 1600;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [VERSION_W-1:0]  cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // data_byte
  logic [BYTE_W-1:0]     s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // ref_a, ref_b, package_ref, object_name, object_flags, serial_size, serial_offset
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // entry_kind
  logic                  m_axis_tuser;

  package_table_entry_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // parser state mirrored by the checker
  logic [VERSION_W-1:0] cur_version;
  logic                 cur_kind;
  logic [POS_W-1:0]     fld_pos;
  logic [BIF_W-1:0]     byte_cnt;
  logic [WORD_W-1:0]    acc;
  logic                 acc_neg;
  logic [WORD_W-1:0]    field_vals [STORE_DEPTH];

  logic [BYTE_W-1:0] byte_q [$];
  record_t           pending_records [$];

  // stimulus-side copy of the settings, used to shape well-formed entries
  logic [VERSION_W-1:0] stim_version;
  logic                 stim_kind;
  logic                 no_idle;

  int unsigned send_gap;
  int unsigned rx_stall;
  int unsigned idle_cycles;
  int unsigned bytes_queued;
  int unsigned bytes_accepted;
  int unsigned records_checked;
  int unsigned export_records;
  int unsigned offset_records;
  int unsigned phases_run;
  int unsigned errors;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_wait();
    if (no_idle || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 11);
  endfunction

  task automatic restart_entry();
    fld_pos  = FLD_REF_A;
    byte_cnt = '0;
    acc      = '0;
    acc_neg  = 1'b0;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VERSION_W-1:0] data);
    if (idx == CFG_PACKAGE_VERSION) cur_version = data;
    else if (idx == CFG_TABLE_KIND) cur_kind = data[0];
    restart_entry();
  endtask

  // advances the entry decode by one byte and queues a record when an entry ends
  task automatic decode_table_byte(input logic [BYTE_W-1:0] b);
    logic              ends;
    logic              raw_dword;
    logic [WORD_W-1:0] val;
    int                sh;
    record_t           rec;
    raw_dword = (fld_pos == FLD_PACKAGE && cur_version >= DWORD_PKG_VERSION) ||
                (fld_pos == FLD_FLAGS && cur_kind);
    if (raw_dword) begin
      acc     = acc | (32'(b) << (8 * byte_cnt[1:0]));
      acc_neg = 1'b0;
      ends    = (byte_cnt >= DWORD_LAST_BYTE);
    end else if (byte_cnt == 0) begin
      acc     = 32'(b[5:0]);
      acc_neg = b[7];
      ends    = !b[6];
    end else begin
      sh   = 6 + 7 * ((int'(byte_cnt) - 1) & 3);
      acc  = acc | (32'(b[6:0]) << sh);
      ends = !b[7] || (byte_cnt >= IDX_LAST_BYTE);
    end
    if (!ends) begin
      byte_cnt = byte_cnt + 1'b1;
    end else begin
      val      = acc_neg ? (32'd0 - acc) : acc;
      acc      = '0;
      acc_neg  = 1'b0;
      byte_cnt = '0;
      if (fld_pos < STORE_DEPTH) field_vals[fld_pos] = val;
      // an export carries an offset only after a positive size
      if (cur_kind && fld_pos == FLD_SIZE) ends = !(!val[31] && val != 0);
      else ends = (fld_pos >= (cur_kind ? FLD_OFFSET : FLD_OBJECT));
      if (!ends) begin
        fld_pos = fld_pos + 1'b1;
      end else begin
        rec.entry_kind  = cur_kind;
        rec.ref_a       = field_vals[0];
        rec.ref_b       = field_vals[1];
        rec.package_ref = field_vals[2];
        rec.object_name = field_vals[3];
        if (cur_kind) begin
          rec.object_flags  = field_vals[4];
          rec.serial_size   = field_vals[5];
          rec.serial_offset = (fld_pos == FLD_OFFSET) ? val : '0;
        end else begin
          rec.object_flags  = '0;
          rec.serial_size   = '0;
          rec.serial_offset = '0;
        end
        pending_records.push_back(rec);
        fld_pos = FLD_REF_A;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%s", msg);
    errors++;
  endtask

  task automatic report_field(input string name, input logic [WORD_W-1:0] got,
                              input logic [WORD_W-1:0] want);
    report_mismatch($sformatf("record %0d: %s is %h, expected %h",
                              records_checked, name, got, want));
  endtask

  task automatic check_record(input record_t got, input record_t want);
    if (got.entry_kind != want.entry_kind)
      report_field("entry_kind", 32'(got.entry_kind), 32'(want.entry_kind));
    if (got.ref_a != want.ref_a) report_field("ref_a", got.ref_a, want.ref_a);
    if (got.ref_b != want.ref_b) report_field("ref_b", got.ref_b, want.ref_b);
    if (got.package_ref != want.package_ref)
      report_field("package_ref", got.package_ref, want.package_ref);
    if (got.object_name != want.object_name)
      report_field("object_name", got.object_name, want.object_name);
    if (got.object_flags != want.object_flags)
      report_field("object_flags", got.object_flags, want.object_flags);
    if (got.serial_size != want.serial_size)
      report_field("serial_size", got.serial_size, want.serial_size);
    if (got.serial_offset != want.serial_offset)
      report_field("serial_offset", got.serial_offset, want.serial_offset);
  endtask

  always @(posedge clk_i) begin : byte_driver
    if (rst_ni) begin
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) begin
        decode_table_byte(s_axis_tdata);
        bytes_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          s_axis_tdata  <= byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap = draw_wait();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : record_monitor
    record_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_records.size() == 0) begin
          report_mismatch($sformatf("record arrived with none outstanding: %h",
                                    {m_axis_tuser, m_axis_tdata}));
        end else begin
          want = pending_records.pop_front();
          check_record(record_t'({m_axis_tuser, m_axis_tdata}), want);
          if (want.entry_kind) export_records++;
          if (want.entry_kind && want.serial_size > 0) offset_records++;
        end
        records_checked++;
        rx_stall = draw_wait();
      end else if (rx_stall != 0) begin
        rx_stall--;
      end
      m_axis_tready <= (rx_stall == 0);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles, %0d records outstanding",
                 idle_cycles, pending_records.size());
        $display("package_table_entry_parser verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [VERSION_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // upper bits of the table kind write are junk and must be ignored
  task automatic set_mode(input logic [VERSION_W-1:0] version, input logic kind);
    stim_version = version;
    stim_kind    = kind;
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_PACKAGE_VERSION, version);
      write_reg(CFG_TABLE_KIND, {15'($urandom), kind});
    end else begin
      write_reg(CFG_TABLE_KIND, {15'($urandom), kind});
      write_reg(CFG_PACKAGE_VERSION, version);
    end
    @(negedge clk_i);
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_index(input logic sign, input int unsigned len, input logic nonzero);
    logic [BYTE_W-1:0] b;
    b    = 8'($urandom);
    b[7] = sign;
    b[6] = (len > 1);
    if (nonzero && b[5:0] == 0) b[0] = 1'b1;
    put_byte(b);
    for (int unsigned i = 1; i < len; i++) begin
      b = 8'($urandom);
      // the fifth byte ends the index whatever its top bit
      if (i < len - 1) b[7] = 1'b1;
      else if (i < IDX_MAX_BYTES - 1) b[7] = 1'b0;
      put_byte(b);
    end
  endtask

  task automatic push_any_index();
    if ($urandom_range(0, 9) == 0) put_byte(8'h00);
    else push_index(1'($urandom), ($urandom_range(0, 3) == 0) ? $urandom_range(4, 5)
                                                               : $urandom_range(1, 3), 1'b0);
  endtask

  task automatic push_dword();
    repeat (4) put_byte(8'($urandom));
  endtask

  task automatic push_entry();
    push_any_index();
    push_any_index();
    if (stim_version >= DWORD_PKG_VERSION) push_dword();
    else push_any_index();
    push_any_index();
    if (stim_kind) begin
      push_dword();
      case ($urandom_range(0, 4))
        0: put_byte(8'h00);
        1: push_index(1'b1, $urandom_range(1, 4), 1'b0);
        default: begin
          push_index(1'b0, $urandom_range(1, 4), 1'b1);
          push_any_index();
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || s_axis_tvalid || m_axis_tvalid || pending_records.size() != 0);
    // a partial entry may still sit in the input stage
    repeat (4) @(negedge clk_i);
    phases_run++;
  endtask

  initial begin : stimulus
    logic [VERSION_W-1:0] version;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PACKAGE_VERSION;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    no_idle       = 1'b0;
    send_gap      = 0;
    rx_stall      = 0;
    idle_cycles   = 0;
    bytes_queued  = 0;
    bytes_accepted  = 0;
    records_checked = 0;
    export_records  = 0;
    offset_records  = 0;
    phases_run      = 0;
    errors          = 0;
    cur_version     = '0;
    cur_kind        = 1'b0;
    stim_version    = '0;
    stim_kind       = 1'b0;
    restart_entry();
    for (int i = 0; i < STORE_DEPTH; i++) field_vals[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // import at reset settings: zero byte, largest one-byte value, negative,
    // and a five-byte index whose last byte keeps its top bit set
    @(negedge clk_i);
    put_byte(8'h00);
    put_byte(8'h3f);
    put_byte(8'hbf);
    repeat (5) put_byte(8'hff);
    wait_drained();

    // export with a raw package dword, positive size and an offset
    set_mode(16'd60, 1'b1);
    put_byte(8'h01);
    put_byte(8'h81);
    put_byte(8'h78); put_byte(8'h56); put_byte(8'h34); put_byte(8'h12);
    put_byte(8'h00);
    put_byte(8'hff); put_byte(8'h00); put_byte(8'haa); put_byte(8'h55);
    put_byte(8'h05);
    put_byte(8'h3e);
    // entry left half done, to be dropped by the next register write
    put_byte(8'h42);
    put_byte(8'h80);
    wait_drained();

    while (bytes_queued < ITEM_TARGET) begin
      case ($urandom_range(0, 4))
        0: version = 16'd0;
        1: version = 16'd59;
        2: version = 16'd60;
        3: version = 16'hffff;
        default: version = 16'($urandom);
      endcase
      set_mode(version, 1'($urandom));
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(4, 40)) put_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(3, 20)) push_entry();
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
      end
      wait_drained();
      no_idle = 1'b0;
    end

    repeat (10) @(negedge clk_i);
    if (pending_records.size() != 0) begin
      report_mismatch($sformatf("%0d records never arrived", pending_records.size()));
    end
    $display("%0d table bytes over %0d settings; %0d records checked",
             bytes_accepted, phases_run, records_checked);
    $display("%0d export records, %0d with an offset; %0d mismatches",
             export_records, offset_records, errors);
    if (errors == 0) begin
      $display("package_table_entry_parser verification clean");
    end else begin
      $display("package_table_entry_parser verification failed");
    end
    $finish;
  end

endmodule
